>>> rtl/mmp_pkg.sv
// Package with shared constants, types and modular arithmetic helpers.
package mmp_pkg;
    localparam int unsigned DEF_MAX_DIM   = 8;
    localparam int unsigned DEF_EXP_WIDTH = 63;
    localparam int unsigned VAL_W         = 30;
    localparam int unsigned IDX_W         = 3;
    localparam int unsigned SIZE_W        = 4;
    localparam logic [VAL_W-1:0] PRIME    = 30'd1000000007;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    // Input beat payload.
    typedef struct packed {
        logic             operation;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] entry_value;
        logic [62:0]      exponent;
    } in_item_t;

    // Output beat payload.
    typedef struct packed {
        logic [VAL_W-1:0] result_value;
        logic [IDX_W-1:0] result_row;
        logic [IDX_W-1:0] result_col;
        logic             last;
    } out_item_t;

    // Which matrix product a multiply pass computes.
    typedef enum logic [1:0] {
        PASS_ACC = 2'b01,
        PASS_SQR = 2'b10
    } pass_t;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

    // Reduces a value below twice the prime.
    function automatic logic [VAL_W-1:0] fold(input logic [VAL_W:0] v);
        logic [VAL_W:0] d;
        begin
            d = v - {1'b0, PRIME};
            fold = d[VAL_W] ? v[VAL_W-1:0] : d[VAL_W-1:0];
        end
    endfunction
endpackage

>>> rtl/mmp_stream_if.sv
// Valid/ready channel interface carrying one payload type.
interface mmp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/mmp_cfg_if.sv
// Configuration write channel carrying the matrix size.
interface mmp_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/mmp_modred.sv
// Pipelined 30x30 multiply, add and reduction modulo the prime.
module mmp_modred
    import mmp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [VAL_W-1:0] a,
    input  logic [VAL_W-1:0] b,
    input  logic [VAL_W-1:0] addend,
    output logic             out_valid,
    output logic [VAL_W-1:0] sum
);
    // Barrett constant floor(2^60 / p); the estimated quotient is at most two short.
    localparam logic [30:0] MU = 31'(64'h1000_0000_0000_0000 / 64'(PRIME));

    // Stage 1: product.
    logic [2*VAL_W-1:0] prod_reg;
    logic [VAL_W-1:0]   add1_reg;
    logic               v1_reg;
    // Stage 2: product plus addend, below p^2 + p.
    logic [2*VAL_W-1:0] x_reg;
    logic               v2_reg;
    // Stage 3: quotient estimate times 2^31.
    logic [61:0]        q_reg;
    logic [VAL_W+2:0]   x3_reg;
    logic               v3_reg;
    // Stage 4: low bits of quotient times the prime.
    logic [VAL_W+2:0]   qp_reg;
    logic [VAL_W+2:0]   x4_reg;
    logic               v4_reg;
    // Stage 5: remainder below three times the prime.
    logic [VAL_W+2:0]   t5_reg;
    logic               v5_reg;
    logic [VAL_W+2:0]   t5;
    logic [VAL_W+2:0]   r1;
    logic [VAL_W+2:0]   r2;
    logic [VAL_W+2:0]   r3;

    // Final reduction of a value below 8p by three compare-subtract steps.
    always_comb
    begin
        t5 = t5_reg;
        r1 = (t5 >= {PRIME, 2'b00}) ? t5 - {PRIME, 2'b00} : t5;
        r2 = (r1 >= {1'b0, PRIME, 1'b0}) ? r1 - {1'b0, PRIME, 1'b0} : r1;
        r3 = (r2 >= {2'b00, PRIME}) ? r2 - {2'b00, PRIME} : r2;
    end

    // Valid pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Data pipeline. The remainder fits in 33 bits, so only the low bits are kept.
    always_ff @(posedge clk)
    begin
        prod_reg <= 60'(a) * 60'(b);
        add1_reg <= addend;
        x_reg    <= prod_reg + 60'(add1_reg);
        q_reg    <= 62'(x_reg[2*VAL_W-1:VAL_W-1]) * 62'(MU);
        x3_reg   <= x_reg[VAL_W+2:0];
        qp_reg   <= 33'(q_reg[61:31]) * 33'(PRIME);
        x4_reg   <= x3_reg;
        t5_reg   <= x4_reg - qp_reg;
    end

    assign out_valid = v5_reg;
    assign sum       = r3[VAL_W-1:0];
endmodule

>>> rtl/mmp_core.sv
// Sequencer and matrix memories for square-and-multiply.
module mmp_core
    import mmp_pkg::*;
#(
    parameter int unsigned MAX_DIM   = DEF_MAX_DIM,
    parameter int unsigned EXP_WIDTH = DEF_EXP_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [SIZE_W-1:0]  size_cfg,
    mmp_stream_if.sink         in_ch,
    mmp_stream_if.source       out_ch
);
    localparam int unsigned DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int unsigned CELLS = MAX_DIM * MAX_DIM;
    localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int unsigned NW    = $clog2(MAX_DIM + 1);
    localparam int unsigned PIPE  = 6;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_INIT  = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_DRAIN = 7'b0001000,
        ST_COPY  = 7'b0010000,
        ST_EMIT  = 7'b0100000,
        ST_WAIT  = 7'b1000000
    } state_t;

    // Memories: base, accumulated, scratch, product temp.
    logic [VAL_W-1:0] base_mem [CELLS];
    logic [VAL_W-1:0] acc_mem  [CELLS];
    logic [VAL_W-1:0] scr_mem  [CELLS];
    logic [VAL_W-1:0] tmp_mem  [CELLS];

    state_t              state_reg, state_next;
    pass_t               pass_reg, pass_next;
    logic [EXP_WIDTH-1:0] exp_reg, exp_next;
    logic [NW-1:0]       n_reg, n_next;
    logic [DW-1:0]       i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [VAL_W-1:0]    part_reg, part_next;
    logic [PIPE-1:0]     cnt_reg, cnt_next;
    logic                emit_pend_reg, emit_pend_next;

    logic [NW-1:0] size_eff;
    logic [AW-1:0] addr_ij, addr_ik, addr_kj;
    logic          last_i, last_j, last_k;
    mac_ctl_t      issue, ctl_d [PIPE];
    logic [DW-1:0] wi_d [PIPE];
    logic [DW-1:0] wj_d [PIPE];
    logic [VAL_W-1:0] ra_reg, rb_reg;
    logic             rv_reg;
    mac_ctl_t         rc_reg;
    logic [DW-1:0]    ri_reg, rj_reg;
    logic             mv;
    logic [VAL_W-1:0] msum;
    logic [VAL_W:0]   ld_sum;
    logic [VAL_W-1:0] ld_val;
    out_item_t        out_reg;
    logic             out_valid_reg;
    logic [VAL_W-1:0] rd_acc_reg;
    logic             accept;
    logic             cp_wr_reg;
    logic             cp_acc_reg;
    logic [AW-1:0]    cp_addr_reg;
    logic [VAL_W-1:0] cp_data_reg;

    // Clamp the configured size to one through MAX_DIM.
    always_comb
    begin
        if (size_cfg == '0)
            size_eff = NW'(1);
        else if (32'(size_cfg) > MAX_DIM)
            size_eff = NW'(MAX_DIM);
        else
            size_eff = NW'(size_cfg);
    end

    assign addr_ij = AW'(32'(i_reg) * MAX_DIM + 32'(j_reg));
    assign addr_ik = AW'(32'(i_reg) * MAX_DIM + 32'(k_reg));
    assign addr_kj = AW'(32'(k_reg) * MAX_DIM + 32'(j_reg));
    assign last_i  = (NW'(i_reg) == n_reg - NW'(1));
    assign last_j  = (NW'(j_reg) == n_reg - NW'(1));
    assign last_k  = (NW'(k_reg) == n_reg - NW'(1));
    assign accept  = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && !out_valid_reg;

    // Load reduction: a 30-bit value is below twice the prime.
    assign ld_sum = {1'b0, in_ch.data.entry_value};
    assign ld_val = fold(ld_sum);

    // Base memory write on loads.
    always_ff @(posedge clk)
    begin
        if (accept && in_ch.data.operation == OP_LOAD
            && 32'(in_ch.data.row) < MAX_DIM && 32'(in_ch.data.col) < MAX_DIM)
            base_mem[AW'(32'(in_ch.data.row) * MAX_DIM + 32'(in_ch.data.col))] <= ld_val;
    end

    // Multiply operand reads are registered. A copy write still in
    // flight holds back the first issue of the next pass.
    assign issue.valid = (state_reg == ST_MUL) && !cp_wr_reg;
    assign issue.first = (k_reg == '0);
    assign issue.last  = last_k;
    always_ff @(posedge clk)
    begin
        ra_reg <= (pass_reg == PASS_ACC) ? acc_mem[addr_ik] : scr_mem[addr_ik];
        rb_reg <= scr_mem[addr_kj];
        rd_acc_reg <= acc_mem[addr_ij];
        rc_reg <= issue;
        ri_reg <= i_reg;
        rj_reg <= j_reg;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg    <= 1'b0;
            cp_wr_reg <= 1'b0;
        end
        else
        begin
            rv_reg    <= issue.valid;
            cp_wr_reg <= (state_reg == ST_INIT) || (state_reg == ST_COPY);
        end
    end

    // Copy source reads are registered; the copy write lands in the following cycle.
    always_ff @(posedge clk)
    begin
        cp_data_reg <= (state_reg == ST_INIT) ? base_mem[addr_ij] : tmp_mem[addr_ij];
        cp_addr_reg <= addr_ij;
        cp_acc_reg  <= (state_reg == ST_COPY) && (pass_reg == PASS_ACC);
    end

    mmp_modred u_modred (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rv_reg),
        .a         (ra_reg),
        .b         (rb_reg),
        .addend    (part_reg),
        .out_valid (mv),
        .sum       (msum)
    );

    // Each k step feeds the previous partial sum, so issue waits for it.
    // Sideband delay line matching the reduction pipeline.
    always_ff @(posedge clk)
    begin
        ctl_d[0] <= rc_reg;
        wi_d[0]  <= ri_reg;
        wj_d[0]  <= rj_reg;
        for (int s = 1; s < PIPE; s++)
        begin
            ctl_d[s] <= ctl_d[s-1];
            wi_d[s]  <= wi_d[s-1];
            wj_d[s]  <= wj_d[s-1];
        end
    end

    // Temp and destination memory writes.
    always_ff @(posedge clk)
    begin
        if (mv && ctl_d[PIPE-2].last)
            tmp_mem[AW'(32'(wi_d[PIPE-2]) * MAX_DIM + 32'(wj_d[PIPE-2]))] <= msum;
        if (state_reg == ST_INIT)
            acc_mem[addr_ij] <= (i_reg == j_reg) ? VAL_W'(1) : '0;
        else if (cp_wr_reg && cp_acc_reg)
            acc_mem[cp_addr_reg] <= cp_data_reg;
        if (cp_wr_reg && !cp_acc_reg)
            scr_mem[cp_addr_reg] <= cp_data_reg;
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        exp_next       = exp_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        part_next      = part_reg;
        cnt_next       = cnt_reg;
        emit_pend_next = emit_pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_ch.data.operation == OP_RUN)
                begin
                    n_next    = size_eff;
                    exp_next  = in_ch.data.exponent[EXP_WIDTH-1:0];
                    i_next    = '0;
                    j_next    = '0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (last_j)
                begin
                    j_next = '0;
                    if (last_i)
                    begin
                        i_next = '0;
                        k_next = '0;
                        part_next = '0;
                        if (exp_reg == '0)
                            state_next = ST_EMIT;
                        else
                        begin
                            pass_next  = exp_reg[0] ? PASS_ACC : PASS_SQR;
                            state_next = ST_MUL;
                        end
                    end
                    else
                        i_next = i_reg + DW'(1);
                end
                else
                    j_next = j_reg + DW'(1);
            end
            ST_MUL:
            begin
                // Issue one term, then wait for its sum to come back.
                if (!cp_wr_reg)
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                if (mv)
                begin
                    part_next = msum;
                    if (last_k)
                    begin
                        k_next    = '0;
                        part_next = '0;
                        if (last_j)
                        begin
                            j_next = '0;
                            if (last_i)
                            begin
                                i_next = '0;
                                state_next = ST_COPY;
                            end
                            else
                            begin
                                i_next = i_reg + DW'(1);
                                state_next = ST_MUL;
                            end
                        end
                        else
                        begin
                            j_next = j_reg + DW'(1);
                            state_next = ST_MUL;
                        end
                    end
                    else
                    begin
                        k_next = k_reg + DW'(1);
                        state_next = ST_MUL;
                    end
                end
            end
            ST_COPY:
            begin
                if (last_j)
                begin
                    j_next = '0;
                    if (last_i)
                    begin
                        i_next = '0;
                        if (pass_reg == PASS_ACC)
                        begin
                            pass_next  = PASS_SQR;
                            state_next = ST_MUL;
                        end
                        else
                        begin
                            exp_next = exp_reg >> 1;
                            if (exp_reg[EXP_WIDTH-1:1] == '0)
                                state_next = ST_EMIT;
                            else
                            begin
                                pass_next  = exp_reg[1] ? PASS_ACC : PASS_SQR;
                                state_next = ST_MUL;
                            end
                        end
                    end
                    else
                        i_next = i_reg + DW'(1);
                end
                else
                    j_next = j_reg + DW'(1);
            end
            ST_EMIT:
            begin
                // Read issued now; the output register loads it in the wait state.
                emit_pend_next = 1'b1;
                state_next     = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    if (emit_pend_reg)
                    begin
                        emit_pend_next = 1'b0;
                        if (last_j)
                        begin
                            j_next = '0;
                            if (last_i)
                            begin
                                i_next = '0;
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                i_next = i_reg + DW'(1);
                                state_next = ST_EMIT;
                            end
                        end
                        else
                        begin
                            j_next = j_reg + DW'(1);
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= PASS_SQR;
            exp_reg       <= '0;
            n_reg         <= NW'(1);
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            part_reg      <= '0;
            cnt_reg       <= '0;
            emit_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            exp_reg       <= exp_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            part_reg      <= part_next;
            cnt_reg       <= cnt_next + PIPE'(ctl_d[PIPE-1].valid);
            emit_pend_reg <= emit_pend_next;
        end
    end

    // Output register; loads the memory word read in the emit state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_WAIT && emit_pend_reg && (!out_valid_reg || out_ch.ready))
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WAIT && emit_pend_reg && (!out_valid_reg || out_ch.ready))
        begin
            out_reg.result_value <= rd_acc_reg;
            out_reg.result_row   <= IDX_W'(i_reg);
            out_reg.result_col   <= IDX_W'(j_reg);
            out_reg.last         <= last_i && last_j;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;
endmodule

>>> rtl/modular_matrix_power.sv
// Top level of the modular matrix power block.
//
// Channels: in_ch takes load beats (operation 0: row, col, entry_value) and
// run beats (operation 1: exponent); out_ch returns one beat per entry of
// base^exponent mod 1000000007, row-major, with last on the final entry.
// cfg_ch writes the matrix size (1 to MAX_DIM; 0 acts as 1, larger clamps).
// Loads are taken one per cycle while the block is idle. A run first sets
// up its matrices, then computes each matrix product term by term: every
// multiply-add term is issued, read from memory and passed through the
// five-stage reduction pipeline, and the next term waits for the previous
// partial sum. Each product is then copied back to its destination memory.
// Each exponent bit costs one squaring and, when set, one more product.
// Results leave one beat at a time, each read after the previous one loads.
// No new beat is taken from a run until its last result is taken.
// Reset clears the sequencer and sets the size to 2; matrix memories are
// not cleared. When the receiver stalls, the result register holds its beat
// and the sequencer waits.
module modular_matrix_power
    import mmp_pkg::*;
#(
    parameter int unsigned MAX_DIM   = DEF_MAX_DIM,
    parameter int unsigned EXP_WIDTH = DEF_EXP_WIDTH
)
(
    input logic          clk,
    input logic          rst_n,
    mmp_cfg_if.sink      cfg_ch,
    mmp_stream_if.sink   in_ch,
    mmp_stream_if.source out_ch
);
    logic [SIZE_W-1:0] size_reg;

    // Size register.
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= SIZE_W'(2);
        else if (cfg_ch.valid)
            size_reg <= cfg_ch.data;
    end

    mmp_core #(
        .MAX_DIM   (MAX_DIM),
        .EXP_WIDTH (EXP_WIDTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .size_cfg (size_reg),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );
endmodule

>>> rtl/mmp_checker.sv
// Port checker for the modular matrix power block and its bind.
module mmp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_last,
    input logic [29:0] out_value
);
    // Results never reach the prime.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_value < 30'd1000000007)
        else $error("result not reduced");

    // No input taken while results are pending.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(in_valid && in_ready))
        else $error("input taken during output");

    // Stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
        else $error("stalled beat changed");
endmodule

bind modular_matrix_power mmp_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_last  (out_ch.data.last),
    .out_value (out_ch.data.result_value)
);
